// ===== design/s2c_pkg.sv =====
// ----------------------------------------------------------------------------
// s2c_pkg
// Shared constants and types for the spherical to Cartesian converter.
// ----------------------------------------------------------------------------
package s2c_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int DATA_BITS_DEF      = 24;
  localparam int TRIG_FRAC_BITS_DEF = 16;

  // pi/4 in Q30 and one in Q30.
  localparam logic [29:0] PI4_Q30 = 30'd843314857;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Number of Taylor terms and register stages of one sine/cosine unit.
  localparam int TERMS    = 5;
  localparam int TRIG_LAT = 2 + 3 * TERMS + 2;

  // Quadrant codes of a binary angle.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } octant_t;

endpackage

// ===== design/s2c_fifo.sv =====
// ----------------------------------------------------------------------------
// s2c_fifo
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module s2c_fifo import s2c_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/s2c_front.sv =====
// ----------------------------------------------------------------------------
// s2c_front
// Accepts points and splits each angle into its octant and in-octant angle.
// ----------------------------------------------------------------------------
module s2c_front import s2c_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int DATA_BITS  = DATA_BITS_DEF,
  localparam int NW = ANGLE_BITS - 2,
  localparam int QW = 2 * (NW + 3) + 4 * DATA_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [ANGLE_BITS-1:0]       colatitude,
  input  logic [ANGLE_BITS-1:0]       longitude,
  input  logic [DATA_BITS-1:0]        radius,
  input  logic signed [DATA_BITS-1:0] vec_colat,
  input  logic signed [DATA_BITS-1:0] vec_lon,
  input  logic signed [DATA_BITS-1:0] vec_radial,
  output logic                        q_wr,
  output logic [QW-1:0]               q_data,
  input  logic                        q_full
);

  localparam int OB = ANGLE_BITS - 3;

  logic          valid;
  logic [QW-1:0] item;
  logic [QW-1:0] item_next;
  logic          take;
  logic [NW-1:0] n_th;
  logic [NW-1:0] n_ph;
  octant_t       oct_th;
  octant_t       oct_ph;

  // Odd octants are reflected so that the in-octant angle runs toward the axis.
  function automatic logic [NW-1:0] fold(input logic [ANGLE_BITS-1:0] a);
    logic [NW-1:0] rest;
    rest = NW'(a[OB-1:0]);
    return a[OB] ? ((NW'(1) << OB) - rest) : rest;
  endfunction

  always_comb begin
    n_th        = fold(colatitude);
    n_ph        = fold(longitude);
    oct_th.quad = colatitude[ANGLE_BITS-1:ANGLE_BITS-2];
    oct_th.swap = colatitude[OB];
    oct_ph.quad = longitude[ANGLE_BITS-1:ANGLE_BITS-2];
    oct_ph.swap = longitude[OB];
    item_next   = {n_th, oct_th, n_ph, oct_ph, radius, vec_colat, vec_lon, vec_radial};
  end

  assign q_wr   = valid;
  assign q_data = item;
  assign full   = valid && q_full;
  assign take   = push && !full;

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || !q_full) begin
      valid <= push;
    end
  end

endmodule

// ===== design/s2c_trig.sv =====
// ----------------------------------------------------------------------------
// s2c_trig
// Pipelined sine and cosine of a folded binary angle by Taylor series.
// ----------------------------------------------------------------------------
module s2c_trig import s2c_pkg::*; #(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  localparam int NW = ANGLE_BITS - 2
) (
  input  logic                             clk,
  input  logic                             ce,
  input  logic [NW-1:0]                    n,
  input  octant_t                          oct,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

  localparam int OB = ANGLE_BITS - 3;
  localparam int F  = TRIG_FRAC_BITS;
  localparam int SH = 30 - F;
  localparam logic [NW+29:0] X_HALF   = (NW+30)'(1) << (OB - 1);
  localparam logic [59:0]    SQ_HALF  = 60'(1) << 29;
  localparam logic [60:0]    TRM_HALF = 61'(1) << 29;

  logic [NW+29:0] xprod;
  logic [59:0]    xsq;
  logic [29:0]    x_r;
  octant_t        oct_r;

  logic [30:0]        ts  [0:TERMS];
  logic [30:0]        tc  [0:TERMS];
  logic signed [32:0] ss  [0:TERMS];
  logic signed [32:0] sc  [0:TERMS];
  logic [29:0]        x2p [0:TERMS];
  octant_t            op  [0:TERMS];

  assign xprod = (NW+30)'(n) * (NW+30)'(PI4_Q30) + X_HALF;
  assign xsq   = 60'(x_r) * 60'(x_r) + SQ_HALF;

  always_ff @(posedge clk) begin
    if (ce) begin
      x_r    <= xprod[OB+29:OB];
      oct_r  <= oct;
      ts[0]  <= 31'(x_r);
      ss[0]  <= 33'(x_r);
      tc[0]  <= ONE_Q30;
      sc[0]  <= 33'(ONE_Q30);
      x2p[0] <= xsq[59:30];
      op[0]  <= oct_r;
    end
  end

  // Each term takes three stages: scale by x^2, reciprocal multiply, correction.
  for (genvar k = 1; k <= TERMS; k++) begin : g_term
    localparam logic [31:0] DS = 32'((2 * k) * (2 * k + 1));
    localparam logic [31:0] DC = 32'((2 * k - 1) * (2 * k));
    localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);

    logic [60:0]        ps_a;
    logic [60:0]        pc_a;
    logic [30:0]        ts_a;
    logic [30:0]        tc_a;
    logic signed [32:0] ss_a;
    logic signed [32:0] sc_a;
    logic [29:0]        x2_a;
    octant_t            op_a;
    logic [31:0]        vs;
    logic [31:0]        vc;
    logic [63:0]        qs_p;
    logic [63:0]        qc_p;
    logic [31:0]        vs_b;
    logic [31:0]        vc_b;
    logic [31:0]        qs_b;
    logic [31:0]        qc_b;
    logic signed [32:0] ss_b;
    logic signed [32:0] sc_b;
    logic [29:0]        x2_b;
    octant_t            op_b;
    logic [31:0]        rs;
    logic [31:0]        rc;
    logic [31:0]        qs;
    logic [31:0]        qc;

    assign ps_a = 61'(ts[k-1]) * 61'(x2p[k-1]) + TRM_HALF;
    assign pc_a = 61'(tc[k-1]) * 61'(x2p[k-1]) + TRM_HALF;
    assign vs   = 32'(ts_a) + (DS >> 1);
    assign vc   = 32'(tc_a) + (DC >> 1);
    assign qs_p = 64'(vs) * 64'(MS);
    assign qc_p = 64'(vc) * 64'(MC);
    assign rs   = vs_b - 32'(qs_b * DS);
    assign rc   = vc_b - 32'(qc_b * DC);
    assign qs   = (rs >= DS) ? qs_b + 1'b1 : qs_b;
    assign qc   = (rc >= DC) ? qc_b + 1'b1 : qc_b;

    always_ff @(posedge clk) begin
      if (ce) begin
        ts_a <= ps_a[60:30];
        tc_a <= pc_a[60:30];
        ss_a <= ss[k-1];
        sc_a <= sc[k-1];
        x2_a <= x2p[k-1];
        op_a <= op[k-1];
        vs_b <= vs;
        vc_b <= vc;
        qs_b <= qs_p[63:32];
        qc_b <= qc_p[63:32];
        ss_b <= ss_a;
        sc_b <= sc_a;
        x2_b <= x2_a;
        op_b <= op_a;
        ts[k]  <= qs[30:0];
        tc[k]  <= qc[30:0];
        x2p[k] <= x2_b;
        op[k]  <= op_b;
        sc[k]  <= (k % 2 == 1) ? sc_b - 33'(qc) : sc_b + 33'(qc);
        // The sine series stops at x^9.
        if (k < TERMS) begin
          ss[k] <= (k % 2 == 1) ? ss_b - 33'(qs) : ss_b + 33'(qs);
        end else begin
          ss[k] <= ss_b;
        end
      end
    end
  end

  logic [30:0]  cl_s;
  logic [30:0]  cl_c;
  logic [30:0]  rd_s;
  logic [30:0]  rd_c;
  logic [F:0]   us_r;
  logic [F:0]   uc_r;
  octant_t      oct_f;
  logic [F:0]   ps;
  logic [F:0]   pc;
  logic signed [F+1:0] sps;
  logic signed [F+1:0] spc;

  function automatic logic [30:0] clamp(input logic signed [32:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > 33'(ONE_Q30)) begin
      return ONE_Q30;
    end
    return v[30:0];
  endfunction

  assign cl_s = clamp(ss[TERMS]);
  assign cl_c = clamp(sc[TERMS]);

  if (SH == 0) begin : g_noround
    assign rd_s = cl_s;
    assign rd_c = cl_c;
  end else begin : g_round
    assign rd_s = (cl_s + (31'(1) << (SH - 1))) >> SH;
    assign rd_c = (cl_c + (31'(1) << (SH - 1))) >> SH;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      us_r  <= rd_s[F:0];
      uc_r  <= rd_c[F:0];
      oct_f <= op[TERMS];
    end
  end

  assign ps  = oct_f.swap ? uc_r : us_r;
  assign pc  = oct_f.swap ? us_r : uc_r;
  assign sps = $signed({1'b0, ps});
  assign spc = $signed({1'b0, pc});

  always_ff @(posedge clk) begin
    if (ce) begin
      case (oct_f.quad)
        QUAD_0: begin
          sin_val <= sps;
          cos_val <= spc;
        end
        QUAD_1: begin
          sin_val <= spc;
          cos_val <= -sps;
        end
        QUAD_2: begin
          sin_val <= -sps;
          cos_val <= -spc;
        end
        default: begin
          sin_val <= -spc;
          cos_val <= sps;
        end
      endcase
    end
  end

endmodule

// ===== design/s2c_back.sv =====
// ----------------------------------------------------------------------------
// s2c_back
// Execution pipeline: angle functions, basis products and final sums.
// ----------------------------------------------------------------------------
module s2c_back import s2c_pkg::*; #(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int DATA_BITS      = DATA_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  localparam int NW = ANGLE_BITS - 2,
  localparam int QW = 2 * (NW + 3) + 4 * DATA_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  logic [QW-1:0]               q_data,
  output logic                        q_rd,
  input  logic                        pop,
  output logic                        empty,
  output logic signed [DATA_BITS:0]   pos_x,
  output logic signed [DATA_BITS:0]   pos_y,
  output logic signed [DATA_BITS:0]   pos_z,
  output logic signed [DATA_BITS:0]   vel_x,
  output logic signed [DATA_BITS:0]   vel_y,
  output logic signed [DATA_BITS:0]   vel_z
);

  localparam int D   = DATA_BITS;
  localparam int F   = TRIG_FRAC_BITS;
  localparam int LAT = TRIG_LAT + 5;
  localparam int DLY = TRIG_LAT + 2;
  localparam int TW  = F + 2;
  localparam int TPW = 2 * TW;
  localparam int DPW = D + 1 + TW;
  localparam int SW  = D + 4;
  localparam logic [TPW-1:0] HALF_T = TPW'(1) << (F - 1);
  localparam logic [DPW-1:0] HALF_D = DPW'(1) << (F - 1);

  logic [LAT-1:0]   vld;
  logic             ce;
  logic [4*D-1:0]   dline [0:DLY-1];
  logic [NW-1:0]    n_th;
  logic [NW-1:0]    n_ph;
  octant_t          oct_th;
  octant_t          oct_ph;
  logic signed [TW-1:0] st;
  logic signed [TW-1:0] ct;
  logic signed [TW-1:0] sp;
  logic signed [TW-1:0] cp;

  assign {n_th, oct_th, n_ph, oct_ph} = q_data[QW-1:4*D];

  // The whole pipeline moves together; it holds while a result waits.
  assign empty = !vld[LAT-1];
  assign ce    = !vld[LAT-1] || pop;
  assign q_rd  = ce && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dline[0] <= q_data[4*D-1:0];
      for (int i = 1; i < DLY; i++) begin
        dline[i] <= dline[i-1];
      end
    end
  end

  s2c_trig #(
    .ANGLE_BITS(ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_trig_th (
    .clk(clk),
    .ce(ce),
    .n(n_th),
    .oct(oct_th),
    .sin_val(st),
    .cos_val(ct)
  );

  s2c_trig #(
    .ANGLE_BITS(ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_trig_ph (
    .clk(clk),
    .ce(ce),
    .n(n_ph),
    .oct(oct_ph),
    .sin_val(sp),
    .cos_val(cp)
  );

  // Round to nearest with halves away from zero.
  function automatic logic signed [TW-1:0] rnd_t(input logic signed [TPW-1:0] p);
    logic [TPW-1:0] mag;
    logic [TPW-1:0] r;
    mag = p[TPW-1] ? (~p + 1'b1) : p;
    r   = (mag + HALF_T) >> F;
    return p[TPW-1] ? -$signed(r[TW-1:0]) : $signed(r[TW-1:0]);
  endfunction

  function automatic logic signed [D+1:0] rnd_d(input logic signed [DPW-1:0] p);
    logic [DPW-1:0] mag;
    logic [DPW-1:0] r;
    mag = p[DPW-1] ? (~p + 1'b1) : p;
    r   = (mag + HALF_D) >> F;
    return p[DPW-1] ? -$signed(r[D+1:0]) : $signed(r[D+1:0]);
  endfunction

  // Trig products.
  logic signed [TPW-1:0] sc_p;
  logic signed [TPW-1:0] ss_p;
  logic signed [TPW-1:0] cc_p;
  logic signed [TPW-1:0] cs_p;
  logic signed [TW-1:0]  st1, ct1, sp1, cp1;
  logic signed [TW-1:0]  st2, ct2, sp2, cp2;
  logic signed [TW-1:0]  sc2, ss2, cc2, cs2;

  always_ff @(posedge clk) begin
    if (ce) begin
      sc_p <= st * cp;
      ss_p <= st * sp;
      cc_p <= ct * cp;
      cs_p <= ct * sp;
      st1  <= st;
      ct1  <= ct;
      sp1  <= sp;
      cp1  <= cp;
      sc2  <= rnd_t(sc_p);
      ss2  <= rnd_t(ss_p);
      cc2  <= rnd_t(cc_p);
      cs2  <= rnd_t(cs_p);
      st2  <= st1;
      ct2  <= ct1;
      sp2  <= sp1;
      cp2  <= cp1;
    end
  end

  // Data products.
  logic signed [D:0]     rr;
  logic signed [D:0]     vc;
  logic signed [D:0]     vl;
  logic signed [D:0]     vr;
  logic signed [DPW-1:0] p_rsc, p_rss, p_rct, p_vccc, p_vlsp, p_vrsc;
  logic signed [DPW-1:0] p_vccs, p_vlcp, p_vrss, p_vrct, p_vcst;
  logic signed [D+1:0]   r_rsc, r_rss, r_rct, r_vccc, r_vlsp, r_vrsc;
  logic signed [D+1:0]   r_vccs, r_vlcp, r_vrss, r_vrct, r_vcst;
  logic signed [SW-1:0]  sum_x;
  logic signed [SW-1:0]  sum_y;
  logic signed [SW-1:0]  sum_z;

  assign rr = $signed({1'b0, dline[DLY-1][4*D-1:3*D]});
  assign vc = $signed({dline[DLY-1][3*D-1], dline[DLY-1][3*D-1:2*D]});
  assign vl = $signed({dline[DLY-1][2*D-1], dline[DLY-1][2*D-1:D]});
  assign vr = $signed({dline[DLY-1][D-1], dline[DLY-1][D-1:0]});

  always_ff @(posedge clk) begin
    if (ce) begin
      p_rsc  <= rr * sc2;
      p_rss  <= rr * ss2;
      p_rct  <= rr * ct2;
      p_vccc <= vc * cc2;
      p_vlsp <= vl * sp2;
      p_vrsc <= vr * sc2;
      p_vccs <= vc * cs2;
      p_vlcp <= vl * cp2;
      p_vrss <= vr * ss2;
      p_vrct <= vr * ct2;
      p_vcst <= vc * st2;
      r_rsc  <= rnd_d(p_rsc);
      r_rss  <= rnd_d(p_rss);
      r_rct  <= rnd_d(p_rct);
      r_vccc <= rnd_d(p_vccc);
      r_vlsp <= rnd_d(p_vlsp);
      r_vrsc <= rnd_d(p_vrsc);
      r_vccs <= rnd_d(p_vccs);
      r_vlcp <= rnd_d(p_vlcp);
      r_vrss <= rnd_d(p_vrss);
      r_vrct <= rnd_d(p_vrct);
      r_vcst <= rnd_d(p_vcst);
    end
  end

  assign sum_x = SW'(r_vccc) - SW'(r_vlsp) + SW'(r_vrsc);
  assign sum_y = SW'(r_vccs) + SW'(r_vlcp) + SW'(r_vrss);
  assign sum_z = SW'(r_vrct) - SW'(r_vcst);

  always_ff @(posedge clk) begin
    if (ce) begin
      pos_x <= r_rsc[D:0];
      pos_y <= r_rss[D:0];
      pos_z <= r_rct[D:0];
      vel_x <= sum_x[D:0];
      vel_y <= sum_y[D:0];
      vel_z <= sum_z[D:0];
    end
  end

endmodule

// ===== design/spherical_to_cartesian_point_vector_core.sv =====
// ----------------------------------------------------------------------------
// spherical_to_cartesian_point_vector_core
// Converts a spherical point and a local-basis vector to Cartesian form.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a word (colatitude, longitude, radius and
// the three vector components) is taken on a clock edge with push high and
// full low. Output side is a queue read port: while empty is low the oldest
// result (pos_x/y/z, vel_x/y/z) is on the ports, and pop takes it.
// A front stage folds each angle into an octant and writes the word into a
// four-entry queue. The back pipeline has 24 stages: two Taylor-series
// sine/cosine units of 19 stages, then trig products, data products, rounding
// and the final sums.
// A pushed word passes the front stage register, then the queue, then the back
// pipeline before empty goes low. Throughput is one word per cycle while no result waits for pop.
// When pop stays low with a result shown, the back pipeline holds; the queue
// then fills and full rises once the front stage can not drain.
// Synchronous reset empties the queue and the pipeline; full and empty read
// low and high respectively in the cycle after reset.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_point_vector_core import s2c_pkg::*; #(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int DATA_BITS      = DATA_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [ANGLE_BITS-1:0]       colatitude,
  input  logic [ANGLE_BITS-1:0]       longitude,
  input  logic [DATA_BITS-1:0]        radius,
  input  logic signed [DATA_BITS-1:0] vec_colat,
  input  logic signed [DATA_BITS-1:0] vec_lon,
  input  logic signed [DATA_BITS-1:0] vec_radial,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [DATA_BITS:0]   pos_x,
  output logic signed [DATA_BITS:0]   pos_y,
  output logic signed [DATA_BITS:0]   pos_z,
  output logic signed [DATA_BITS:0]   vel_x,
  output logic signed [DATA_BITS:0]   vel_y,
  output logic signed [DATA_BITS:0]   vel_z
);

  localparam int NW = ANGLE_BITS - 2;
  localparam int QW = 2 * (NW + 3) + 4 * DATA_BITS;

  logic          q_wr;
  logic [QW-1:0] q_wdata;
  logic          q_full;
  logic          q_rd;
  logic [QW-1:0] q_rdata;
  logic          q_empty;

  s2c_front #(
    .ANGLE_BITS(ANGLE_BITS),
    .DATA_BITS(DATA_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .colatitude(colatitude),
    .longitude(longitude),
    .radius(radius),
    .vec_colat(vec_colat),
    .vec_lon(vec_lon),
    .vec_radial(vec_radial),
    .q_wr(q_wr),
    .q_data(q_wdata),
    .q_full(q_full)
  );

  s2c_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(q_wr),
    .wr_data(q_wdata),
    .full(q_full),
    .rd_en(q_rd),
    .rd_data(q_rdata),
    .empty(q_empty)
  );

  s2c_back #(
    .ANGLE_BITS(ANGLE_BITS),
    .DATA_BITS(DATA_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_data(q_rdata),
    .q_rd(q_rd),
    .pop(pop),
    .empty(empty),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .vel_x(vel_x),
    .vel_y(vel_y),
    .vel_z(vel_z)
  );

endmodule

// ===== design/s2c_checker.sv =====
// ----------------------------------------------------------------------------
// s2c_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module s2c_checker import s2c_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      push,
  input logic                      full,
  input logic                      pop,
  input logic                      empty,
  input logic signed [DATA_BITS:0] pos_x,
  input logic signed [DATA_BITS:0] vel_z
);

  // Reset leaves nothing to read and room to write.
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("reset did not clear the queue ports");

  // A shown result may not vanish, and its pos_x and vel_z may not change, before it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pos_x) && $stable(vel_z)))
    else $error("result changed while stalled");

  // Without a write the input side can not become full.
  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    (!push && !full) |=> !full)
    else $error("full rose without a write");

endmodule

bind spherical_to_cartesian_point_vector_core s2c_checker #(
  .DATA_BITS(DATA_BITS)
) u_s2c_checker (
  .clk(clk),
  .rst(rst),
  .push(push),
  .full(full),
  .pop(pop),
  .empty(empty),
  .pos_x(pos_x),
  .vel_z(vel_z)
);
